[rtl/olr_pkg.sv]
// Package for the overstrike line renderer.
// Item kinds, queue entry, line-store cell and back-end state types.
// No dependencies.
package olr_pkg;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_US = 8'h5F;

  localparam int ATTR_BOLD_BIT  = 0;
  localparam int ATTR_UNDER_BIT = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_BACKSPACE,
    KIND_NEWLINE,
    KIND_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       newline_after;
  } item_t;

  typedef struct packed {
    logic [1:0] attr;
    logic [7:0] ch;
  } cell_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DRAIN,
    BK_CLOSE
  } back_state_t;

endpackage

[rtl/overstrike_line_renderer.sv]
// Top level of the overstrike line renderer.
// Instantiates olr_front and olr_back; uses olr_pkg.
//
// Takes the bytes of a text line followed by an end item and renders
// backspace overstrikes: a repeated byte marks a cell bold, an underscore
// under or over a character marks it underlined, a different byte
// overwrites. An item transfers on a rising edge with start high and busy
// low; busy rises only when the four-entry input queue is full. Byte items
// are resolved by the back end with a read of the line-store cell, then a
// write of the merged cell; backspace and newline bytes need no store
// access, and NUL bytes never leave the front end. An end item drains the
// line at one result per cycle and closes with one result carrying the
// trailing attribute reset and the newline request; the line store, cursor
// and stop flag are then clear for the next line. Results appear for one
// cycle with strobe high and cannot be held off by the receiver, so it must
// take every strobed transfer.
module overstrike_line_renderer #(
  parameter int LINE_WIDTH = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  input  logic       newline_after,
  output logic       strobe,
  output logic [7:0] out_char,
  output logic       attr_reset,
  output logic       bold_on,
  output logic       underline_on,
  output logic       closing,
  output logic       newline_out,
  output logic       last
);
  import olr_pkg::*;

  // queue head between front and back
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  olr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .ch            (ch),
    .end_of_line   (end_of_line),
    .newline_after (newline_after),
    .busy          (busy),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back end owns the line store and the drain sequencing
  olr_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .strobe       (strobe),
    .out_char     (out_char),
    .attr_reset   (attr_reset),
    .bold_on      (bold_on),
    .underline_on (underline_on),
    .closing      (closing),
    .newline_out  (newline_out),
    .last         (last)
  );

endmodule

[rtl/olr_front.sv]
// Front end: accepts items, sorts them by kind, drops NUL bytes,
// and queues them for the back end. Depends on olr_pkg.
module olr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [7:0]     ch,
  input  logic           end_of_line,
  input  logic           newline_after,
  output logic           busy,
  output logic           q_valid,
  output olr_pkg::item_t q_item,
  input  logic           q_pop
);
  import olr_pkg::*;

  item_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               accept;
  logic               push;
  logic               pop;
  item_t              item_in;

  always_comb begin
    item_in.ch            = ch;
    item_in.newline_after = newline_after;
    if (end_of_line) begin
      item_in.kind = KIND_END;
    end else if (ch == CH_BS) begin
      item_in.kind = KIND_BACKSPACE;
    end else if (ch == CH_NL) begin
      item_in.kind = KIND_NEWLINE;
    end else begin
      item_in.kind = KIND_BYTE;
    end
  end

  assign busy    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign accept  = start && !busy;
  // NUL bytes have no effect at all, so they never enter the queue
  assign push    = accept && (end_of_line || (ch != 8'h00));
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/olr_back.sv]
// Back end: line store with per-cell valid bits, cursor, overstrike
// update and line drain. Depends on olr_pkg.
module olr_back #(
  parameter int LINE_WIDTH = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  olr_pkg::item_t q_item,
  output logic           q_pop,
  output logic           strobe,
  output logic [7:0]     out_char,
  output logic           attr_reset,
  output logic           bold_on,
  output logic           underline_on,
  output logic           closing,
  output logic           newline_out,
  output logic           last
);
  import olr_pkg::*;

  localparam int CW = $clog2(LINE_WIDTH + 1);
  localparam int IW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam logic [CW-1:0] LW = CW'(LINE_WIDTH);

  cell_t             mem [LINE_WIDTH];
  cell_t             rd_data;
  logic [IW-1:0]     rd_addr;
  logic              rd_en;
  logic              wr_en;
  cell_t             wr_data;

  back_state_t       state;
  back_state_t       state_next;
  logic [LINE_WIDTH-1:0] valid;
  logic [CW-1:0]     cursor;
  logic              stopped;
  logic [CW-1:0]     idx;
  logic [1:0]        lastattr;
  logic              nl_pend;
  logic              rd_pend;
  logic [7:0]        byte_hold;

  logic              take;
  logic              cur_full;
  logic              issue;
  logic              close_now;
  logic              old_valid;
  cell_t             new_cell;
  logic [1:0]        cur_attr;
  logic              change;

  assign cur_full  = (cursor >= LW);
  assign old_valid = valid[cursor[IW-1:0]];
  assign issue     = (state == BK_DRAIN) && (idx < LW) && valid[idx[IW-1:0]];
  assign close_now = (state == BK_CLOSE) && !rd_pend;
  assign cur_attr  = rd_data.attr;
  assign change    = (cur_attr != lastattr);

  // overstrike merge of the held byte into the cell just read
  always_comb begin
    new_cell = rd_data;
    if (!old_valid) begin
      new_cell.ch   = byte_hold;
      new_cell.attr = '0;
    end else if (rd_data.ch == byte_hold) begin
      new_cell.attr[ATTR_BOLD_BIT] = 1'b1;
    end else if (rd_data.ch == CH_US) begin
      new_cell.ch                   = byte_hold;
      new_cell.attr[ATTR_UNDER_BIT] = 1'b1;
    end else if (byte_hold == CH_US) begin
      new_cell.attr[ATTR_UNDER_BIT] = 1'b1;
    end else begin
      new_cell.ch = byte_hold;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    take       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cursor[IW-1:0];
    wr_en      = 1'b0;
    wr_data    = new_cell;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_END) begin
            state_next = BK_DRAIN;
          end else if (q_item.kind == KIND_BYTE && !stopped && !cur_full) begin
            take       = 1'b1;
            rd_en      = 1'b1;
            state_next = BK_UPDATE;
          end
        end
      end
      BK_UPDATE: begin
        wr_en      = 1'b1;
        state_next = BK_IDLE;
      end
      BK_DRAIN: begin
        rd_addr = idx[IW-1:0];
        rd_en   = issue;
        if (!issue) begin
          state_next = BK_CLOSE;
        end
      end
      BK_CLOSE: begin
        if (!rd_pend) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cursor[IW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_hold <= q_item.ch;
    end
    if (q_pop && q_item.kind == KIND_END) begin
      nl_pend <= q_item.newline_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      cursor   <= '0;
      stopped  <= 1'b0;
      idx      <= '0;
      lastattr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (rd_pend) begin
        lastattr <= cur_attr;
      end
      if (q_pop && state == BK_IDLE) begin
        case (q_item.kind)
          KIND_END: begin
            idx      <= '0;
            lastattr <= '0;
          end
          KIND_BACKSPACE: begin
            if (!stopped && cursor != '0) begin
              cursor <= cursor - 1'b1;
            end
          end
          KIND_NEWLINE: begin
            stopped <= 1'b1;
          end
          KIND_BYTE: begin
            if (!stopped && cur_full) begin
              stopped <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (wr_en) begin
        valid[cursor[IW-1:0]] <= 1'b1;
        cursor <= cursor + 1'b1;
        if ((cursor + 1'b1) >= LW) begin
          stopped <= 1'b1;
        end
      end
      if (close_now) begin
        valid   <= '0;
        cursor  <= '0;
        stopped <= 1'b0;
      end
    end
  end

  // result register: one character per read, then the closing result
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= rd_pend || close_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_char     <= rd_data.ch;
      attr_reset   <= change;
      bold_on      <= change && cur_attr[ATTR_BOLD_BIT];
      underline_on <= change && cur_attr[ATTR_UNDER_BIT];
      closing      <= 1'b0;
      newline_out  <= 1'b0;
      last         <= 1'b0;
    end else if (close_now) begin
      out_char     <= 8'h00;
      attr_reset   <= (lastattr != 2'b00);
      bold_on      <= 1'b0;
      underline_on <= 1'b0;
      closing      <= 1'b1;
      newline_out  <= nl_pend;
      last         <= 1'b1;
    end
  end

endmodule

[test/overstrike_line_renderer_tb.sv]
// Self-checking testbench for overstrike_line_renderer.
// Uses olr_pkg for the control byte codes and attribute bit positions.
// Drives lines of bytes through the start/busy handshake and checks every strobed result.
module overstrike_line_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olr_pkg::*;

  localparam int LW = 63;

  // Byte values used by the directed lines; codes with a meaning to the
  // block come from the package.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_B   = 8'h42;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_HI  = 8'h80;
  localparam logic [7:0] CH_MAX = 8'hFF;

  // One rendered output transfer as the predictor expects it.
  typedef struct packed {
    logic [7:0] glyph;
    logic       attr_off;
    logic       bold;
    logic       under;
    logic       close;
    logic       nl;
    logic       fin;
  } render_t;

  logic       clk;
  logic       rst           = 1'b1;
  logic       start         = 1'b0;
  logic       busy;
  logic [7:0] ch            = 8'h00;
  logic       end_of_line   = 1'b0;
  logic       newline_after = 1'b0;
  logic       strobe;
  logic [7:0] out_char;
  logic       attr_reset;
  logic       bold_on;
  logic       underline_on;
  logic       closing;
  logic       newline_out;
  logic       last;

  overstrike_line_renderer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .ch           (ch),
    .end_of_line  (end_of_line),
    .newline_after(newline_after),
    .strobe       (strobe),
    .out_char     (out_char),
    .attr_reset   (attr_reset),
    .bold_on      (bold_on),
    .underline_on (underline_on),
    .closing      (closing),
    .newline_out  (newline_out),
    .last         (last)
  );

  // Predicted line state, updated once per accepted transfer.
  logic [7:0]  line_chars [LW];
  logic [1:0]  line_attrs [LW];
  int unsigned line_cursor;
  bit          line_halted;

  render_t     pending_glyphs [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          no_gaps    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_line_state();
    for (int i = 0; i < LW; i++) begin
      line_chars[i] = 8'h00;
      line_attrs[i] = 2'b00;
    end
    line_cursor = 0;
    line_halted = 1'b0;
  endfunction

  // Apply one line byte at the cursor.
  function automatic void absorb_byte(logic [7:0] b);
    int unsigned pos;
    pos = line_cursor;
    if (line_halted || b == CH_NUL) return;
    if (b == CH_NL) begin
      line_halted = 1'b1;
      return;
    end
    if (b == CH_BS) begin
      if (line_cursor > 0) line_cursor--;
      return;
    end
    if (pos >= LW) begin
      line_halted = 1'b1;
      return;
    end
    if (line_chars[pos] == CH_NUL) begin
      line_chars[pos] = b;
    end else if (line_chars[pos] == b) begin
      // same byte struck twice, underscore included: bold
      line_attrs[pos][ATTR_BOLD_BIT] = 1'b1;
    end else if (line_chars[pos] == CH_US) begin
      // underscore under a character: keep the character
      line_chars[pos] = b;
      line_attrs[pos][ATTR_UNDER_BIT] = 1'b1;
    end else if (b == CH_US) begin
      line_attrs[pos][ATTR_UNDER_BIT] = 1'b1;
    end else begin
      // plain overwrite keeps whatever attributes the cell had
      line_chars[pos] = b;
    end
    line_cursor = pos + 1;
    if (line_cursor >= LW) line_halted = 1'b1;
  endfunction

  // End of line: queue one result per stored character, then the closing one.
  function automatic void render_line(logic nla);
    logic [1:0] prev_attr;
    logic [1:0] a;
    logic       chg;
    render_t    r;
    prev_attr = 2'b00;
    for (int i = 0; i < LW && line_chars[i] != CH_NUL; i++) begin
      a          = line_attrs[i];
      chg        = (a != prev_attr);
      r          = '0;
      r.glyph    = line_chars[i];
      r.attr_off = chg;
      r.bold     = chg && a[ATTR_BOLD_BIT];
      r.under    = chg && a[ATTR_UNDER_BIT];
      pending_glyphs.push_back(r);
      prev_attr  = a;
    end
    r          = '0;
    r.attr_off = (prev_attr != 2'b00);
    r.close    = 1'b1;
    r.nl       = nla;
    r.fin      = 1'b1;
    pending_glyphs.push_back(r);
    clear_line_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every strobe is a transfer.
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    render_t want;
    forever begin
      @(posedge clk);
      if (!rst && strobe) begin
        if (pending_glyphs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual out_char %0h closing %0b",
                   $time, out_char, closing);
          mismatches++;
        end else begin
          want = pending_glyphs.pop_front();
          compare_field("out_char", want.glyph, out_char);
          compare_field("attr_reset", 8'(want.attr_off), 8'(attr_reset));
          compare_field("bold_on", 8'(want.bold), 8'(bold_on));
          compare_field("underline_on", 8'(want.under), 8'(underline_on));
          compare_field("closing", 8'(want.close), 8'(closing));
          compare_field("newline_out", 8'(want.nl), 8'(newline_out));
          compare_field("last", 8'(want.fin), 8'(last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long stretch.
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      ch    <= 8'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // One transfer; start stays high if the next item follows at once.
  task automatic send_item(input logic [7:0] b, input logic eol, input logic nla);
    start         <= 1'b1;
    ch            <= b;
    end_of_line   <= eol;
    newline_after <= nla;
    do @(posedge clk); while (busy);
    if (eol) render_line(nla);
    else absorb_byte(b);
    items_sent++;
    idle_gap();
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(b, 1'b0, 1'($urandom));
  endtask

  task automatic send_end(input logic nla);
    send_item(8'($urandom), 1'b1, nla);
  endtask

  // Hold the sender off until every queued result has been seen.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_glyphs.size() != 0);
  endtask

  // Line of mostly strike/backspace/strike pairs plus some noise bytes.
  task automatic send_random_line(input int unsigned steps);
    int unsigned r;
    logic [7:0]  first;
    logic [7:0]  second;
    for (int k = 0; k < steps; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        first = ($urandom_range(0, 3) == 0) ? CH_US : 8'($urandom_range(1, 255));
        case ($urandom_range(0, 2))
          0: second = first;
          1: second = CH_US;
          default: second = 8'($urandom_range(1, 255));
        endcase
        send_byte(first);
        if ($urandom_range(0, 4) != 0) begin
          send_byte(CH_BS);
          send_byte(second);
        end
      end else if (r < 75) begin
        send_byte(8'($urandom));
      end else if (r < 83) begin
        send_byte(CH_BS);
      end else if (r < 87) begin
        send_byte(CH_NUL);
      end else if (r < 90) begin
        send_byte(CH_NL);
      end else begin
        send_byte(CH_US);
      end
    end
    send_end(1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty lines give only the closing result, with and without newline.
  task automatic test_empty_lines();
    send_end(1'b0);
    send_end(1'b1);
  endtask

  // Bold, underline both ways, double underscore and overwrite of a bold cell.
  task automatic test_overstrike_rules();
    send_byte(CH_A);   send_byte(CH_BS); send_byte(CH_A);
    send_byte(CH_US);  send_byte(CH_BS); send_byte(CH_B);
    send_byte(CH_C);   send_byte(CH_BS); send_byte(CH_US);
    send_byte(CH_US);  send_byte(CH_BS); send_byte(CH_US);
    send_byte(CH_MAX); send_byte(CH_BS); send_byte(CH_MAX);
    send_byte(CH_BS);  send_byte(CH_HI);
    send_end(1'b1);
  endtask

  // Backspace at cell zero, NUL dropped, newline stops intake.
  task automatic test_intake_limits();
    send_byte(CH_BS);
    send_byte(CH_NUL);
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte(CH_BS);
    send_byte(CH_NL);
    send_byte(CH_A);
    send_end(1'b0);
  endtask

  // Fill every cell; the bytes after that, backspace included, are ignored.
  task automatic test_full_line();
    for (int k = 0; k < LW; k++) send_byte(8'($urandom_range(8'h20, 8'hFF)));
    send_byte(CH_BS);
    send_byte(8'($urandom_range(1, 255)));
    send_byte(CH_BS);
    send_end(1'($urandom));
  endtask

  // Sender pauses until the previous line has fully drained, then goes on.
  task automatic test_drain_pause();
    send_random_line(4);
    wait_drained();
    send_random_line(3);
    wait_drained();
  endtask

  task automatic test_random_lines();
    int unsigned target;
    int unsigned steps;
    target = items_sent + 20;
    while (items_sent < target) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      steps   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      send_random_line(steps);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_line_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_lines();
    test_overstrike_rules();
    test_intake_limits();
    test_full_line();
    test_drain_pause();
    test_random_lines();

    // last line may still be draining; allow a full line plus slack after
    wait_drained();
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("overstrike_line_renderer_tb passed");
    end else begin
      $display("overstrike_line_renderer_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("overstrike_line_renderer_tb failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/olr_pkg.sv
rtl/olr_front.sv
rtl/olr_back.sv
rtl/overstrike_line_renderer.sv
test/overstrike_line_renderer_tb.sv
